// File: rtl/core/ecis_pkg.sv
// ============================================================================
// ecis_pkg
// Shared types and constants for the event census interval statistics block.
// ============================================================================
package ecis_pkg;

  // Number of event kinds tracked (1 to 64).
  localparam int NUM_KINDS = 35;
  localparam int KIND_W    = 6;
  localparam int IDX_W     = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

  // Configuration port.
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam logic REG_LIMIT   = 1'b0;   // register index, taken from paddr[2]
  localparam logic [7:0] LIMIT_RESET = 8'd128;

  // Item actions.
  localparam logic [1:0] ACT_CALL  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [KIND_W-1:0] kind;
    logic [31:0]       elapsed_ticks;
  } in_item_t;

  typedef struct packed {
    logic        kind_valid;
    logic [31:0] current_count;
    logic [31:0] last_count;
    logic [31:0] pair_count;
    logic [31:0] total_count;
    logic [31:0] min_count;
    logic [31:0] max_count;
    logic [31:0] cost_sum;
    logic [7:0]  cost_samples;
    logic [31:0] cost_min;
    logic [31:0] cost_max;
    logic [31:0] intervals_closed;
  } out_item_t;

  // One statistics table entry per kind.
  typedef struct packed {
    logic [31:0] open_cnt;
    logic [31:0] last_cnt;
    logic [31:0] pair_sum;
    logic [31:0] total_sum;
    logic [31:0] min_cnt;
    logic [31:0] max_cnt;
    logic [31:0] cost_sum;
    logic [7:0]  cost_samples;
    logic [31:0] cost_min;
    logic [31:0] cost_max;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath.
  typedef struct packed {
    logic load;     // latch the accepted request
    logic rd;       // read the entry at the current address
    logic adv;      // step the address and read the next entry
    logic wr;       // write back the updated entry
    logic finish;   // apply the block-wide effect of the request
    logic emit;     // move the result to the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_kind_ok;  // kind of the request on the input is in range
    logic last;        // current address is the last one of the walk
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

// File: rtl/core/ecis_ram.sv
// ============================================================================
// ecis_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ecis_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ecis_ctrl.sv
// ============================================================================
// ecis_ctrl
// Request sequencer: walks one entry for calls and reads, every entry for begin
// and end, none for an out-of-range kind, then hands the result to the output register.
// ============================================================================
module ecis_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ecis_pkg::status_t status,
  output ecis_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          // An out-of-range kind touches nothing and reports straight away.
          state_nxt = status.in_kind_ok ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.wr = 1'b1;
        if (status.last) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// File: rtl/core/ecis_datapath.sv
// ============================================================================
// ecis_datapath
// Statistics table, entry update logic, block-wide state, limit register
// and output register.
// ============================================================================
module ecis_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ecis_pkg::in_item_t                  in_data,
  input  ecis_pkg::cmd_t                      cmd,
  output ecis_pkg::status_t                   status,
  input  logic                                cfg_wr,
  input  logic [ecis_pkg::PADDR_W-1:0]        paddr,
  input  logic [ecis_pkg::PDATA_W-1:0]        pwdata,
  output logic [ecis_pkg::PDATA_W-1:0]        prdata,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ecis_pkg::out_item_t                 out_data
);

  ecis_pkg::in_item_t                item_r;
  logic [ecis_pkg::IDX_W-1:0]        addr_r;
  logic [ecis_pkg::IDX_W-1:0]        addr_inc;
  logic [ecis_pkg::IDX_W-1:0]        rd_addr;
  logic [ecis_pkg::IDX_W-1:0]        kind_idx;
  logic                              single_r;
  logic                              armed_r;
  logic [31:0]                       inum_r;
  logic [7:0]                        limit_r;
  logic [ecis_pkg::NUM_KINDS-1:0]    vld_r;
  logic                              rd_vld_r;
  logic                              rd_en;
  logic [ecis_pkg::ENTRY_W-1:0]      ram_rdata;
  ecis_pkg::entry_t                  ent;
  ecis_pkg::entry_t                  ent_new;
  ecis_pkg::out_item_t               res_r;
  ecis_pkg::out_item_t               res_out;
  ecis_pkg::out_item_t               out_data_r;
  logic                              out_valid_r;
  logic                              cfg_hit;

  // ---------------------------------------------------------------- status
  assign status.in_kind_ok =
    ({1'b0, in_data.kind} < (ecis_pkg::KIND_W + 1)'(ecis_pkg::NUM_KINDS));
  assign status.last     = single_r || (addr_r == ecis_pkg::IDX_W'(ecis_pkg::NUM_KINDS - 1));
  assign status.out_free = !out_valid_r || !out_stall;

  // ------------------------------------------------------------- addressing
  assign kind_idx = item_r.kind[ecis_pkg::IDX_W-1:0];
  assign addr_inc = addr_r + ecis_pkg::IDX_W'(1);
  assign rd_addr  = cmd.adv ? addr_inc : addr_r;
  assign rd_en    = cmd.rd || cmd.adv;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r   <= in_data;
      // Calls and reads touch their own entry; begin and end walk the table.
      single_r <= (in_data.action == ecis_pkg::ACT_CALL) ||
                  (in_data.action == ecis_pkg::ACT_READ);
      if ((in_data.action == ecis_pkg::ACT_CALL) || (in_data.action == ecis_pkg::ACT_READ)) begin
        addr_r <= in_data.kind[ecis_pkg::IDX_W-1:0];
      end else begin
        addr_r <= '0;
      end
    end else if (cmd.adv) begin
      addr_r <= addr_inc;
    end
  end

  // ------------------------------------------------------------------ table
  ecis_ram #(
    .WIDTH (ecis_pkg::ENTRY_W),
    .DEPTH (ecis_pkg::NUM_KINDS),
    .ADDR_W(ecis_pkg::IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr),
    .wr_addr(addr_r),
    .wr_data(ent_new),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  // An entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.wr) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign ent = rd_vld_r ? ecis_pkg::entry_t'(ram_rdata) : '0;

  // ----------------------------------------------------------- entry update
  always_comb begin
    ent_new = ent;
    unique case (item_r.action)
      ecis_pkg::ACT_CALL: begin
        if (armed_r) begin
          ent_new.open_cnt = ent.open_cnt + 32'd1;
          if (ent.cost_samples < limit_r) begin
            ent_new.cost_sum = ent.cost_sum + item_r.elapsed_ticks;
            if ((ent.cost_samples == 8'd0) || (item_r.elapsed_ticks < ent.cost_min)) begin
              ent_new.cost_min = item_r.elapsed_ticks;
            end
            if (item_r.elapsed_ticks > ent.cost_max) begin
              ent_new.cost_max = item_r.elapsed_ticks;
            end
            ent_new.cost_samples = ent.cost_samples + 8'd1;
          end
        end
      end
      ecis_pkg::ACT_BEGIN: begin
        ent_new.open_cnt = '0;
      end
      ecis_pkg::ACT_END: begin
        ent_new.last_cnt  = ent.open_cnt;
        // The pair sum restarts on every even-numbered interval.
        ent_new.pair_sum  = (inum_r[0] ? ent.pair_sum : 32'd0) + ent.open_cnt;
        ent_new.total_sum = ent.total_sum + ent.open_cnt;
        if ((inum_r == 32'd0) || (ent.open_cnt < ent.min_cnt)) begin
          ent_new.min_cnt = ent.open_cnt;
        end
        if (ent.open_cnt > ent.max_cnt) begin
          ent_new.max_cnt = ent.open_cnt;
        end
      end
      ecis_pkg::ACT_READ: begin
        ent_new = ent;
      end
      default: ent_new = ent;
    endcase
  end

  // ------------------------------------------------------ block-wide state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      inum_r  <= '0;
    end else if (cmd.finish) begin
      if (item_r.action == ecis_pkg::ACT_BEGIN) begin
        armed_r <= 1'b1;
      end else if (item_r.action == ecis_pkg::ACT_END) begin
        armed_r <= 1'b0;
        inum_r  <= inum_r + 32'd1;
      end
    end
  end

  // ------------------------------------------------------- limit register
  assign cfg_hit = (paddr[2] == ecis_pkg::REG_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= ecis_pkg::LIMIT_RESET;
    end else if (cfg_wr && cfg_hit) begin
      limit_r <= pwdata[7:0];
    end
  end

  assign prdata = cfg_hit ? {24'd0, limit_r} : '0;

  // --------------------------------------------------------------- results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= '0;
    end else if (cmd.wr && (addr_r == kind_idx)) begin
      res_r.kind_valid    <= 1'b1;
      res_r.current_count <= ent_new.open_cnt;
      res_r.last_count    <= ent_new.last_cnt;
      res_r.pair_count    <= ent_new.pair_sum;
      res_r.total_count   <= ent_new.total_sum;
      res_r.min_count     <= ent_new.min_cnt;
      res_r.max_count     <= ent_new.max_cnt;
      res_r.cost_sum      <= ent_new.cost_sum;
      res_r.cost_samples  <= ent_new.cost_samples;
      res_r.cost_min      <= ent_new.cost_min;
      res_r.cost_max      <= ent_new.cost_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    res_out                  = res_r;
    res_out.intervals_closed = inum_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/event_census_interval_stats.sv
// ============================================================================
// event_census_interval_stats
// Per-kind call census with interval counts and sampled cost statistics.
// ============================================================================
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | in_data   (ecis_pkg::in_item_t)
//  result   | out_valid/out_stall | out_data  (ecis_pkg::out_item_t)
//  config   | psel/penable/pready | paddr, pwdata, pwrite, prdata
//
//  A call or read request steps through the read, step and result states;
//  begin and end requests step once per entry, since the table, with one read
//  port, is walked one entry per cycle. An out-of-range kind skips the table.
//  Reset clears the per-entry valid bits at once, so no clearing pass runs.
//  A stalled result holds in the output register; the block then waits in
//  its result state before taking the next request.
//
module event_census_interval_stats (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ecis_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ecis_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ecis_pkg::PADDR_W-1:0]   paddr,
  input  logic [ecis_pkg::PDATA_W-1:0]   pwdata,
  output logic [ecis_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  ecis_pkg::cmd_t    cmd;
  ecis_pkg::status_t status;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  ecis_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  ecis_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .cfg_wr   (cfg_wr),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/ecis_checker.sv
// ============================================================================
// ecis_checker
// Port-level checks for the event census block, bound to the top level.
// ============================================================================
module ecis_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ecis_pkg::out_item_t out_data
);

  // No result is pending right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // An ignored kind reports no per-kind statistics.
  a_bad_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.kind_valid) |->
      (out_data.current_count == 32'd0 && out_data.total_count == 32'd0 &&
       out_data.cost_samples == 8'd0 && out_data.cost_max == 32'd0 &&
       out_data.max_count == 32'd0))
    else $error("nonzero statistics for an out-of-range kind");

  // Sampled cost extremes stay ordered, and the interval extremes too.
  a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.cost_min <= out_data.cost_max && out_data.min_count <= out_data.max_count))
    else $error("minimum above maximum");

endmodule

bind event_census_interval_stats ecis_checker u_ecis_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
